// ----- hdl/pfe_pkg.sv -----
// ----------------------------------------------------------------------------
// pfe_pkg
// Shared types, constants and helper functions of the Playfair digraph
// encryptor.
// ----------------------------------------------------------------------------
package pfe_pkg;

    localparam int unsigned SIDE     = 5;
    localparam int unsigned CELLS    = SIDE * SIDE;
    localparam int unsigned ALPHABET = 26;

    typedef logic [4:0] t_letter;
    typedef logic [4:0] t_place;
    typedef logic [2:0] t_coord;

    localparam t_letter LETTER_I = 5'd8;
    localparam t_letter LETTER_J = 5'd9;
    localparam t_letter LETTER_X = 5'd23;

    typedef enum logic [1:0] {
        CMD_NEW_KEY = 2'd0,
        CMD_KEY     = 2'd1,
        CMD_MSG     = 2'd2,
        CMD_END     = 2'd3
    } t_cmd;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SEAL,
        S_RD_A,
        S_RD_B,
        S_CALC,
        S_ADDR0,
        S_ADDR1,
        S_FETCH,
        S_EMIT
    } t_state;

    // Requests from the sequencer to the square store.
    typedef struct packed {
        logic    clear;
        logic    place_en;
        t_letter place_letter;
    } t_store_ctl;

    function automatic t_coord row_of(input t_place p);
        t_coord r;
        if (p >= t_place'(4 * SIDE)) begin
            r = 3'd4;
        end else if (p >= t_place'(3 * SIDE)) begin
            r = 3'd3;
        end else if (p >= t_place'(2 * SIDE)) begin
            r = 3'd2;
        end else if (p >= t_place'(SIDE)) begin
            r = 3'd1;
        end else begin
            r = 3'd0;
        end
        return r;
    endfunction

    function automatic t_place times_side(input t_coord r);
        return t_place'({2'b00, r} << 2) + t_place'({2'b00, r});
    endfunction

    function automatic t_coord col_of(input t_place p);
        t_place rem;
        rem = p - times_side(row_of(p));
        return rem[2:0];
    endfunction

    // Step by one along a row or column, wrapping at the edge of the square.
    function automatic t_coord step_wrap(input t_coord v);
        return (v == t_coord'(SIDE - 1)) ? 3'd0 : v + 3'd1;
    endfunction

endpackage

// ----- hdl/pfe_if.sv -----
// ----------------------------------------------------------------------------
// pfe_in_if / pfe_out_if
// Valid/ready channels for command items and cipher pair items.
// ----------------------------------------------------------------------------
interface pfe_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] cmd;
    logic [4:0] letter;

    modport source (output valid, output cmd, output letter, input ready);
    modport sink   (input valid, input cmd, input letter, output ready);
endinterface

interface pfe_out_if;
    logic       valid;
    logic       ready;
    logic [4:0] first_cipher;
    logic [4:0] second_cipher;

    modport source (output valid, output first_cipher, output second_cipher, input ready);
    modport sink   (input valid, input first_cipher, input second_cipher, output ready);
endinterface

// ----- hdl/pfe_coord.sv -----
// ----------------------------------------------------------------------------
// pfe_coord
// Shared cell address unit: maps the places of a pair to the cell index of
// one of its two cipher letters by the row, column or rectangle rule.
// ----------------------------------------------------------------------------
module pfe_coord (
    input  pfe_pkg::t_place i_pa,
    input  pfe_pkg::t_place i_pb,
    input  logic            i_second,
    output pfe_pkg::t_place o_cell
);
    import pfe_pkg::*;

    t_coord w_ra, w_ca, w_rb, w_cb;
    t_coord w_row_own, w_col_own, w_col_other;

    assign w_ra = row_of(i_pa);
    assign w_ca = col_of(i_pa);
    assign w_rb = row_of(i_pb);
    assign w_cb = col_of(i_pb);

    assign w_row_own   = i_second ? w_rb : w_ra;
    assign w_col_own   = i_second ? w_cb : w_ca;
    assign w_col_other = i_second ? w_ca : w_cb;

    always_comb begin
        if (w_ra == w_rb) begin
            o_cell = times_side(w_row_own) + t_place'({2'b00, step_wrap(w_col_own)});
        end else if (w_ca == w_cb) begin
            o_cell = times_side(step_wrap(w_row_own)) + t_place'({2'b00, w_col_own});
        end else begin
            o_cell = times_side(w_row_own) + t_place'({2'b00, w_col_other});
        end
    end

endmodule

// ----- hdl/pfe_store.sv -----
// ----------------------------------------------------------------------------
// pfe_store
// The square: cell memory, letter place memory, used marks and fill count.
// Places a letter only if it is new and the square is not full.
// ----------------------------------------------------------------------------
module pfe_store (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  pfe_pkg::t_store_ctl  i_ctl,
    input  pfe_pkg::t_letter     i_place_addr,
    input  pfe_pkg::t_place      i_cell_addr,
    output pfe_pkg::t_place      o_place_data,
    output pfe_pkg::t_letter     o_cell_data
);
    import pfe_pkg::*;

    t_letter             r_cells  [CELLS];
    t_place              r_places [ALPHABET];
    logic [ALPHABET-1:0] r_used;
    t_place              r_fill;
    t_place              r_place_rd;
    t_letter             r_cell_rd;
    logic                w_do_place;

    assign w_do_place = i_ctl.place_en && !r_used[i_ctl.place_letter]
                        && (r_fill < t_place'(CELLS));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clear) begin
            r_used <= '0;
            r_fill <= '0;
        end else if (w_do_place) begin
            r_used[i_ctl.place_letter] <= 1'b1;
            r_fill                     <= r_fill + t_place'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_do_place) begin
            r_cells[r_fill]                <= i_ctl.place_letter;
            r_places[i_ctl.place_letter]   <= r_fill;
        end
        r_place_rd <= r_places[i_place_addr];
        r_cell_rd  <= r_cells[i_cell_addr];
    end

    assign o_place_data = r_place_rd;
    assign o_cell_data  = r_cell_rd;

endmodule

// ----- hdl/pfe_ctrl.sv -----
// ----------------------------------------------------------------------------
// pfe_ctrl
// Sequencer: decodes command items, sweeps the alphabet to seal the square,
// and walks a pair through place and cell lookups to the output register.
// ----------------------------------------------------------------------------
module pfe_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    pfe_in_if.sink              i_in,
    pfe_out_if.source           o_out,
    output pfe_pkg::t_store_ctl o_store,
    output pfe_pkg::t_letter    o_place_addr,
    output pfe_pkg::t_place     o_cell_addr,
    input  pfe_pkg::t_place     i_place_data,
    input  pfe_pkg::t_letter    i_cell_data
);
    import pfe_pkg::*;

    t_state  r_state, n_state;
    logic    r_sealed;
    logic    r_held_valid;
    logic    r_prior_valid;
    t_letter r_held, r_prior;
    t_letter r_a, r_b;
    t_letter r_seal_idx;
    t_place  r_pa, r_pb;
    t_letter r_c0, r_c1;
    logic    r_out_valid;
    t_letter r_out_first, r_out_second;

    logic    w_ready, w_acc, w_ok, w_slot_free;
    t_cmd    w_cmd;
    t_letter w_fold, w_msg;

    assign w_cmd       = t_cmd'(i_in.cmd);
    assign w_acc       = i_in.valid && w_ready;
    assign w_ok        = i_in.letter < t_letter'(ALPHABET);
    assign w_fold      = (i_in.letter == LETTER_J) ? LETTER_I : i_in.letter;
    assign w_msg       = (r_prior_valid && w_fold == r_prior) ? LETTER_X : w_fold;
    assign w_slot_free = !r_out_valid || o_out.ready;

    pfe_coord u_coord (
        .i_pa     (r_pa),
        .i_pb     (r_pb),
        .i_second (r_state == S_ADDR1),
        .o_cell   (o_cell_addr)
    );

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    unique case (w_cmd)
                        CMD_NEW_KEY: n_state = S_IDLE;
                        CMD_KEY:     n_state = S_IDLE;
                        CMD_MSG: begin
                            if (w_ok) begin
                                if (!r_sealed) begin
                                    n_state = S_SEAL;
                                end else if (r_held_valid) begin
                                    n_state = S_RD_A;
                                end
                            end
                        end
                        CMD_END: begin
                            if (r_held_valid) begin
                                n_state = S_RD_A;
                            end
                        end
                    endcase
                end
            end
            S_SEAL: begin
                // A pair is waiting exactly when the held letter was consumed.
                if (r_seal_idx == t_letter'(ALPHABET - 1)) begin
                    n_state = r_held_valid ? S_IDLE : S_RD_A;
                end
            end
            S_RD_A:  n_state = S_RD_B;
            S_RD_B:  n_state = S_CALC;
            S_CALC:  n_state = S_ADDR0;
            S_ADDR0: n_state = S_ADDR1;
            S_ADDR1: n_state = S_FETCH;
            S_FETCH: n_state = S_EMIT;
            S_EMIT: begin
                if (w_slot_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        w_ready               = i_rst_n && (r_state == S_IDLE);
        o_store.clear         = w_acc && (w_cmd == CMD_NEW_KEY);
        o_store.place_en      = 1'b0;
        o_store.place_letter  = w_fold;
        o_place_addr          = r_b;
        unique case (r_state)
            S_IDLE: begin
                o_store.place_en = w_acc && (w_cmd == CMD_KEY) && w_ok && !r_sealed;
            end
            S_SEAL: begin
                o_store.place_en     = (r_seal_idx != LETTER_J);
                o_store.place_letter = r_seal_idx;
            end
            S_RD_A: o_place_addr = r_a;
            default: ;
        endcase
    end

    assign i_in.ready          = w_ready;
    assign o_out.valid         = r_out_valid;
    assign o_out.first_cipher  = r_out_first;
    assign o_out.second_cipher = r_out_second;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_sealed      <= 1'b0;
            r_held_valid  <= 1'b0;
            r_prior_valid <= 1'b0;
            r_seal_idx    <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_IDLE && w_acc) begin
                unique case (w_cmd)
                    CMD_NEW_KEY: begin
                        r_sealed      <= 1'b0;
                        r_held_valid  <= 1'b0;
                        r_prior_valid <= 1'b0;
                    end
                    CMD_KEY: ;
                    CMD_MSG: begin
                        if (w_ok) begin
                            r_prior_valid <= 1'b1;
                            r_held_valid  <= !r_held_valid;
                            r_seal_idx    <= '0;
                        end
                    end
                    CMD_END: begin
                        r_held_valid  <= 1'b0;
                        r_prior_valid <= 1'b0;
                    end
                endcase
            end
            if (r_state == S_SEAL) begin
                r_seal_idx <= r_seal_idx + t_letter'(1);
                if (r_seal_idx == t_letter'(ALPHABET - 1)) begin
                    r_sealed <= 1'b1;
                end
            end
            if (r_state == S_EMIT && w_slot_free) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && w_acc) begin
            if (w_cmd == CMD_MSG && w_ok) begin
                r_prior <= w_msg;
                if (r_held_valid) begin
                    r_a <= r_held;
                    r_b <= w_msg;
                end else begin
                    r_held <= w_msg;
                end
            end else if (w_cmd == CMD_END) begin
                r_a <= r_held;
                r_b <= LETTER_X;
            end
        end
        if (r_state == S_RD_B) begin
            r_pa <= i_place_data;
        end
        if (r_state == S_CALC) begin
            r_pb <= i_place_data;
        end
        if (r_state == S_ADDR1) begin
            r_c0 <= i_cell_data;
        end
        if (r_state == S_FETCH) begin
            r_c1 <= i_cell_data;
        end
        if (r_state == S_EMIT && w_slot_free) begin
            r_out_first  <= r_c0;
            r_out_second <= r_c1;
        end
    end

endmodule

// ----- hdl/playfair_digraph_encryptor_core.sv -----
// ----------------------------------------------------------------------------
// playfair_digraph_encryptor_core
// A new-key, key letter or end item without a pending letter is handled in
// the idle state. The first message letter after a new key seals the square
// with a sweep over the alphabet. A message or end item completing a pair
// steps through states RD_A to EMIT before the next item is accepted, plus
// any wait for the output register to free: the place and cell tables each
// have a single registered read port, so the two places and the two cipher
// cells are fetched in turn. Only the end item emits a padded pair.
// ----------------------------------------------------------------------------
module playfair_digraph_encryptor_core (
    input  logic      i_clk,
    input  logic      i_rst_n,
    pfe_in_if.sink    i_in,
    pfe_out_if.source o_out
);
    import pfe_pkg::*;

    t_store_ctl w_store;
    t_letter    w_place_addr;
    t_place     w_cell_addr;
    t_place     w_place_data;
    t_letter    w_cell_data;

    pfe_store u_store (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (w_store),
        .i_place_addr (w_place_addr),
        .i_cell_addr  (w_cell_addr),
        .o_place_data (w_place_data),
        .o_cell_data  (w_cell_data)
    );

    pfe_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .o_out        (o_out),
        .o_store      (w_store),
        .o_place_addr (w_place_addr),
        .o_cell_addr  (w_cell_addr),
        .i_place_data (w_place_data),
        .i_cell_data  (w_cell_data)
    );

endmodule

// ----- hdl/pfe_chk.sv -----
// ----------------------------------------------------------------------------
// pfe_chk
// Port-level checks of the encryptor, bound to the top level.
// ----------------------------------------------------------------------------
module pfe_chk (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic [1:0] i_in_cmd,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [4:0] i_out_first,
    input logic [4:0] i_out_second
);
    import pfe_pkg::*;

    logic w_acc;
    assign w_acc = i_in_valid && i_in_ready;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("output item dropped before it was taken");

    a_key_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc && (i_in_cmd == CMD_NEW_KEY || i_in_cmd == CMD_KEY) |=> i_in_ready)
        else $error("key item did not complete in one cycle");

    a_no_instant_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc |=> !$rose(i_out_valid))
        else $error("result appeared directly after an accepted item");

    a_cipher_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_first < 5'd26) && (i_out_second < 5'd26)
                        && (i_out_first != LETTER_J) && (i_out_second != LETTER_J))
        else $error("cipher letter outside the square");

endmodule

bind playfair_digraph_encryptor_core pfe_chk u_pfe_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in.valid),
    .i_in_ready   (i_in.ready),
    .i_in_cmd     (i_in.cmd),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_out_first  (o_out.first_cipher),
    .i_out_second (o_out.second_cipher)
);
